[hdl/dlf_pkg.sv]
// Shared types, constants and arithmetic helpers for the deinterlace line filter.
package dlf_pkg;

    localparam int PIX_W          = 8;
    localparam int MAX_LINE_WIDTH = 4096;
    localparam int CNT_W          = 13;
    localparam int WIN            = 7;   // left-right window taps
    localparam int LAG            = 4;   // columns in flight between input and result
    localparam int FLUSH_W        = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int S_TDATA_W      = 12 * PIX_W;
    localparam int M_TDATA_W      = PIX_W;

    localparam logic [CNT_W-1:0]   MIN_WIDTH      = CNT_W'(4);
    localparam logic [CNT_W-1:0]   MAX_WIDTH      = CNT_W'(MAX_LINE_WIDTH);
    localparam logic [CNT_W-1:0]   LINE_WIDTH_RST = CNT_W'(720);
    localparam logic [CNT_W-1:0]   FIRST_EMIT_COL = CNT_W'(3);
    localparam logic [FLUSH_W-1:0] FLUSH_BEATS    = FLUSH_W'(3);
    localparam logic [1:0]         MODE_EDGE_LIMIT = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPORAL_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTIONAL_CHECK = 2'd2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN-1:0]   win_t;
    typedef logic signed [9:0] sval_t;

    // input beat; last field sits in the lowest bits
    typedef struct packed {
        pix_t late_down2;
        pix_t late_up2;
        pix_t early_down2;
        pix_t early_up2;
        pix_t late_center;
        pix_t early_center;
        pix_t next_below;
        pix_t next_above;
        pix_t prev_below;
        pix_t prev_above;
        pix_t cur_below;
        pix_t cur_above;
    } in_beat_t;

    // temporal average and motion bound of one column
    typedef struct packed {
        pix_t center;
        pix_t bound;
    } pend_t;

    function automatic pix_t absdiff(input pix_t x, input pix_t y);
        return (x > y) ? pix_t'(x - y) : pix_t'(y - x);
    endfunction

    function automatic sval_t smax(input sval_t x, input sval_t y);
        return (x > y) ? x : y;
    endfunction

    function automatic sval_t smin(input sval_t x, input sval_t y);
        return (x < y) ? x : y;
    endfunction

endpackage

[hdl/dlf_bound.sv]
// Temporal average and motion bound of one column, computed on the input beat.
module dlf_bound import dlf_pkg::*; (
    input  in_beat_t px,
    input  logic     edge_check,
    output pend_t    res
);

    always_comb begin
        logic [8:0] sum_c, sum_p, sum_n, sum_u, sum_d;
        pix_t       t0, t1, t2;
        sval_t      d, base, bu, fd, dcb, dca, ua, fb, hi, lo, b;

        sum_c = {1'b0, px.early_center} + {1'b0, px.late_center};
        d     = sval_t'({2'b00, sum_c[8:1]});
        t0    = pix_t'(absdiff(px.early_center, px.late_center) >> 1);
        sum_p = {1'b0, absdiff(px.prev_above, px.cur_above)}
              + {1'b0, absdiff(px.prev_below, px.cur_below)};
        sum_n = {1'b0, absdiff(px.next_above, px.cur_above)}
              + {1'b0, absdiff(px.next_below, px.cur_below)};
        t1    = sum_p[8:1];
        t2    = sum_n[8:1];
        base  = smax(smax(sval_t'({2'b00, t0}), sval_t'({2'b00, t1})),
                     sval_t'({2'b00, t2}));

        sum_u = {1'b0, px.early_up2} + {1'b0, px.late_up2};
        sum_d = {1'b0, px.early_down2} + {1'b0, px.late_down2};
        bu    = sval_t'({2'b00, sum_u[8:1]});
        fd    = sval_t'({2'b00, sum_d[8:1]});
        dcb   = d - sval_t'({2'b00, px.cur_below});
        dca   = d - sval_t'({2'b00, px.cur_above});
        ua    = bu - sval_t'({2'b00, px.cur_above});
        fb    = fd - sval_t'({2'b00, px.cur_below});
        hi    = smax(smax(dcb, dca), smin(ua, fb));
        lo    = smin(smin(dcb, dca), smax(ua, fb));

        b = edge_check ? smax(smax(base, lo), -hi) : base;

        res.center = d[PIX_W-1:0];
        res.bound  = b[PIX_W-1:0];   // always within 0..255
    end

endmodule

[hdl/dlf_predict.sv]
// Spatial prediction for the window centre, clamped to the motion bound.
module dlf_predict import dlf_pkg::*; (
    input  win_t  above,
    input  win_t  below,
    input  pend_t tmp,
    input  logic  dir_check,
    output pix_t  pixel
);

    function automatic logic [9:0] score3(input pix_t a0, input pix_t b0,
                                          input pix_t a1, input pix_t b1,
                                          input pix_t a2, input pix_t b2);
        return {2'b00, absdiff(a0, b0)} + {2'b00, absdiff(a1, b1)}
             + {2'b00, absdiff(a2, b2)};
    endfunction

    function automatic pix_t avg2(input pix_t x, input pix_t y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[8:1];
    endfunction

    always_comb begin
        logic signed [10:0] best;
        logic signed [10:0] sm1, sm2, sp1, sp2;
        pix_t               pred;
        sval_t              p, top, bot;

        pred = avg2(above[3], below[3]);
        best = $signed({1'b0, score3(above[2], below[2], above[3], below[3],
                                     above[4], below[4])}) - 11'sd1;
        sm1  = $signed({1'b0, score3(above[1], below[3], above[2], below[4],
                                     above[3], below[5])});
        sm2  = $signed({1'b0, score3(above[0], below[4], above[1], below[5],
                                     above[2], below[6])});
        sp1  = $signed({1'b0, score3(above[3], below[1], above[4], below[2],
                                     above[5], below[3])});
        sp2  = $signed({1'b0, score3(above[4], below[0], above[5], below[1],
                                     above[6], below[2])});

        if (dir_check) begin
            // leftward lean, one then two columns
            if (sm1 < best) begin
                best = sm1;
                pred = avg2(above[2], below[4]);
                if (sm2 < best) begin
                    best = sm2;
                    pred = avg2(above[1], below[5]);
                end
            end
            // rightward lean
            if (sp1 < best) begin
                best = sp1;
                pred = avg2(above[4], below[2]);
                if (sp2 < best) begin
                    pred = avg2(above[5], below[1]);
                end
            end
        end

        p   = sval_t'({2'b00, pred});
        top = sval_t'({2'b00, tmp.center}) + sval_t'({2'b00, tmp.bound});
        bot = sval_t'({2'b00, tmp.center}) - sval_t'({2'b00, tmp.bound});
        if (p > top) begin
            p = top;
        end else if (p < bot) begin
            p = bot;
        end
        pixel = p[PIX_W-1:0];
    end

endmodule

[hdl/deinterlace_line_filter.sv]
// Top level of the deinterlace line filter: windows, flush control and output register.
//
// Builds one missing line of an interlaced field, one pixel column per input beat.
// Each beat carries the twelve neighbor pixels of one column; the rows above and
// below run through 7-tap left-right windows, so the result for column x leaves
// with the beat of column x+3 and is registered at the output. Columns 0..2
// of a line produce no result; the last column (line_width-1) produces four:
// its own and three flush results that repeat the edge pixel. The block takes one
// beat per cycle while the output is not stalled; at the end of each line s_tready
// stays low while the flush results pass the single output register. Columns left of 0
// repeat column 0. line_width is saturated to 4..4096. temporal_mode applies to a
// beat when it is taken, directional_check when its result is formed; change
// either only while the block is idle. m_tlast marks the last result of an input
// beat, m_tuser marks the result of the final column of the line.
module deinterlace_line_filter import dlf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: cur_above, cur_below, prev_above, prev_below, next_above, next_below,
    //        early_center, late_center, early_up2, early_down2, late_up2, late_down2
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // tdata: out_pixel
    output logic                  m_tlast,   // run_last
    output logic                  m_tuser    // tuser: line_done
);

    // config
    logic [CNT_W-1:0]   line_width_reg;
    logic [1:0]         temporal_mode_reg;
    logic               dir_check_reg;

    // control
    logic [CNT_W-1:0]   col_cnt_reg;
    logic [FLUSH_W-1:0] flush_cnt_reg;
    logic               emit_pend_reg;   // window holds a column to emit
    logic               tag_last_reg;
    logic               tag_done_reg;
    logic               m_tvalid_reg;

    // payload
    win_t               above_win_reg, below_win_reg;
    pend_t              pend_reg [LAG];
    pix_t               edge_a_reg, edge_b_reg;
    pix_t               m_pixel_reg;
    logic               m_last_reg, m_done_reg;

    in_beat_t           in_f;
    pend_t              in_tmp;
    pix_t               pred_pixel;
    logic [CNT_W-1:0]   width_sat;
    logic               last_col;
    logic               out_load, adv_ok, flushing, in_acc, flush_step;

    assign in_f = in_beat_t'(s_tdata);

    always_comb begin
        if (line_width_reg < MIN_WIDTH) begin
            width_sat = MIN_WIDTH;
        end else if (line_width_reg > MAX_WIDTH) begin
            width_sat = MAX_WIDTH;
        end else begin
            width_sat = line_width_reg;
        end
    end

    assign last_col   = col_cnt_reg >= (width_sat - CNT_W'(1));
    assign out_load   = emit_pend_reg && (!m_tvalid_reg || m_tready);
    assign adv_ok     = !emit_pend_reg || out_load;
    assign flushing   = flush_cnt_reg != '0;
    assign s_tready   = adv_ok && !flushing;
    assign in_acc     = s_tvalid && s_tready;
    assign flush_step = flushing && adv_ok;

    dlf_bound u_bound (
        .px         (in_f),
        .edge_check (temporal_mode_reg < MODE_EDGE_LIMIT),
        .res        (in_tmp)
    );

    // window centre (tap 3) pairs with the oldest pending column
    dlf_predict u_predict (
        .above     (above_win_reg),
        .below     (below_win_reg),
        .tmp       (pend_reg[LAG-1]),
        .dir_check (dir_check_reg),
        .pixel     (pred_pixel)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg    <= LINE_WIDTH_RST;
            temporal_mode_reg <= '0;
            dir_check_reg     <= 1'b0;
            col_cnt_reg       <= '0;
            flush_cnt_reg     <= '0;
            emit_pend_reg     <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_LINE_WIDTH:        line_width_reg    <= cfg_wdata;
                    REG_TEMPORAL_MODE:     temporal_mode_reg <= cfg_wdata[1:0];
                    REG_DIRECTIONAL_CHECK: dir_check_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (in_acc) begin
                emit_pend_reg <= (col_cnt_reg >= FIRST_EMIT_COL) || last_col;
                if (last_col) begin
                    col_cnt_reg   <= '0;
                    flush_cnt_reg <= FLUSH_BEATS;
                end else begin
                    col_cnt_reg <= col_cnt_reg + CNT_W'(1);
                end
            end else if (flush_step) begin
                emit_pend_reg <= 1'b1;
                flush_cnt_reg <= flush_cnt_reg - FLUSH_W'(1);
            end else if (out_load) begin
                emit_pend_reg <= 1'b0;
            end
        end
    end

    // windows, pending columns and output payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            if (col_cnt_reg == '0) begin
                // left edge: whole window takes column 0
                for (int i = 0; i < WIN; i++) begin
                    above_win_reg[i] <= in_f.cur_above;
                    below_win_reg[i] <= in_f.cur_below;
                end
            end else begin
                for (int i = 0; i < WIN - 1; i++) begin
                    above_win_reg[i] <= above_win_reg[i+1];
                    below_win_reg[i] <= below_win_reg[i+1];
                end
                above_win_reg[WIN-1] <= in_f.cur_above;
                below_win_reg[WIN-1] <= in_f.cur_below;
            end
            pend_reg[0] <= in_tmp;
            for (int i = 1; i < LAG; i++) begin
                pend_reg[i] <= pend_reg[i-1];
            end
            edge_a_reg   <= in_f.cur_above;
            edge_b_reg   <= in_f.cur_below;
            tag_last_reg <= !last_col;
            tag_done_reg <= 1'b0;
        end else if (flush_step) begin
            // right edge: repeat the last column
            for (int i = 0; i < WIN - 1; i++) begin
                above_win_reg[i] <= above_win_reg[i+1];
                below_win_reg[i] <= below_win_reg[i+1];
            end
            above_win_reg[WIN-1] <= edge_a_reg;
            below_win_reg[WIN-1] <= edge_b_reg;
            pend_reg[0] <= '0;
            for (int i = 1; i < LAG; i++) begin
                pend_reg[i] <= pend_reg[i-1];
            end
            tag_last_reg <= flush_cnt_reg == FLUSH_W'(1);
            tag_done_reg <= flush_cnt_reg == FLUSH_W'(1);
        end

        if (out_load) begin
            m_pixel_reg <= pred_pixel;
            m_last_reg  <= tag_last_reg;
            m_done_reg  <= tag_done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_pixel_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

endmodule

[hdl/dlf_checker.sv]
// Port-level assertions for the deinterlace line filter and their bind.
module dlf_checker import dlf_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // the final column of a line always closes the run of its input beat
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("line_done without run_last");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind deinterlace_line_filter dlf_checker u_dlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[bench/dlf_line_checker.sv]
// Line filter checker: watches the beats, predicts every interpolated pixel and compares.
module dlf_line_checker import dlf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic                  m_tuser,
    output int                    fail_total,
    output int                    results_awaited,
    output int                    results_checked
);

    typedef struct packed {
        pix_t pixel;
        logic run_last;
        logic line_done;
    } px_result_t;

    px_result_t expected_px[$];

    logic [CNT_W-1:0] width_reg;
    logic [1:0]       mode_reg;
    logic             dir_en;
    logic [CNT_W-1:0] col;
    int               above_w[WIN];
    int               below_w[WIN];
    int               pend_avg[LAG];
    int               pend_bound[LAG];
    int               fail_count = 0;
    int               checked_count = 0;

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic void shift_windows(input int a, input int b);
        for (int i = 0; i < WIN - 1; i++) begin
            above_w[i] = above_w[i+1];
            below_w[i] = below_w[i+1];
        end
        above_w[WIN-1] = a;
        below_w[WIN-1] = b;
    endfunction

    function automatic void shift_pending(input int d, input int bnd);
        for (int i = LAG - 1; i > 0; i--) begin
            pend_avg[i]   = pend_avg[i-1];
            pend_bound[i] = pend_bound[i-1];
        end
        pend_avg[0]   = d;
        pend_bound[0] = bnd;
    endfunction

    // SAD of three pixel pairs along direction j
    function automatic int dir_cost(input int j);
        return iabs(above_w[2+j] - below_w[2-j]) + iabs(above_w[3+j] - below_w[3-j])
             + iabs(above_w[4+j] - below_w[4-j]);
    endfunction

    // pixel for the window center column, clamped to the oldest in-flight bound
    function automatic pix_t center_pixel();
        int pred, d, bnd, best, s;
        pred = (above_w[3] + below_w[3]) >> 1;
        d    = pend_avg[LAG-1];
        bnd  = pend_bound[LAG-1];
        if (dir_en) begin
            best = iabs(above_w[2] - below_w[2]) + iabs(above_w[3] - below_w[3])
                 + iabs(above_w[4] - below_w[4]) - 1;
            s = dir_cost(-1);
            if (s < best) begin
                best = s;
                pred = (above_w[2] + below_w[4]) >> 1;
                s = dir_cost(-2);
                if (s < best) begin
                    best = s;
                    pred = (above_w[1] + below_w[5]) >> 1;
                end
            end
            s = dir_cost(1);
            if (s < best) begin
                best = s;
                pred = (above_w[4] + below_w[2]) >> 1;
                s = dir_cost(2);
                if (s < best) begin
                    best = s;
                    pred = (above_w[5] + below_w[1]) >> 1;
                end
            end
        end
        if (pred > d + bnd)
            pred = d + bnd;
        else if (pred < d - bnd)
            pred = d - bnd;
        return pix_t'(pred);
    endfunction

    function automatic void predict_column(input in_beat_t b);
        int ca, cb, pa, pb, na, nb, ec, lc, eu, ed, lu, ld;
        int d, bnd, bu, fd, hi, lo, wdt, n_res;
        logic [CNT_W-1:0] n;
        logic last;
        px_result_t res[4];
        ca = b.cur_above;    cb = b.cur_below;
        pa = b.prev_above;   pb = b.prev_below;
        na = b.next_above;   nb = b.next_below;
        ec = b.early_center; lc = b.late_center;
        eu = b.early_up2;    ed = b.early_down2;
        lu = b.late_up2;     ld = b.late_down2;
        wdt = width_reg;
        if (wdt < 4) wdt = 4;
        if (wdt > MAX_LINE_WIDTH) wdt = MAX_LINE_WIDTH;
        n = col;
        last = (int'(n) >= wdt - 1);

        d   = (ec + lc) >> 1;
        bnd = imax(imax(iabs(ec - lc) >> 1, (iabs(pa - ca) + iabs(pb - cb)) >> 1),
                   (iabs(na - ca) + iabs(nb - cb)) >> 1);
        if (mode_reg < MODE_EDGE_LIMIT) begin
            bu  = (eu + lu) >> 1;
            fd  = (ed + ld) >> 1;
            hi  = imax(imax(d - cb, d - ca), imin(bu - ca, fd - cb));
            lo  = imin(imin(d - cb, d - ca), imax(bu - ca, fd - cb));
            bnd = imax(imax(bnd, lo), -hi);
        end

        if (n == 0) begin
            for (int i = 0; i < WIN; i++) begin
                above_w[i] = ca;
                below_w[i] = cb;
            end
        end else begin
            shift_windows(ca, cb);
        end
        shift_pending(d, bnd);

        for (int i = 0; i < 4; i++) res[i] = '0;
        n_res = 0;
        if (n >= FIRST_EMIT_COL) begin
            res[0].pixel = center_pixel();
            n_res = 1;
        end
        if (last) begin
            // flush: edge pixel repeated to the right
            for (int i = 0; i < 3; i++) begin
                shift_windows(ca, cb);
                shift_pending(0, 0);
                if (int'(n) - 2 + i >= 0) begin
                    res[n_res].pixel = center_pixel();
                    n_res++;
                end
            end
            res[n_res-1].line_done = 1'b1;
            col = '0;
        end else begin
            col = n + 1'b1;
        end
        if (n_res > 0) res[n_res-1].run_last = 1'b1;
        for (int i = 0; i < n_res; i++) expected_px.push_back(res[i]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_result();
        px_result_t want;
        if (expected_px.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat pixel=%0d last=%0b done=%0b",
                                      m_tdata, m_tlast, m_tuser));
        end else begin
            want = expected_px.pop_front();
            checked_count++;
            if (m_tdata !== want.pixel)
                report_mismatch($sformatf("out_pixel got %0d want %0d", m_tdata, want.pixel));
            if (m_tlast !== want.run_last)
                report_mismatch($sformatf("run_last got %0b want %0b", m_tlast, want.run_last));
            if (m_tuser !== want.line_done)
                report_mismatch($sformatf("line_done got %0b want %0b", m_tuser, want.line_done));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = LINE_WIDTH_RST;
            mode_reg  = '0;
            dir_en    = 1'b0;
            col       = '0;
            for (int i = 0; i < WIN; i++) begin
                above_w[i] = 0;
                below_w[i] = 0;
            end
            for (int i = 0; i < LAG; i++) begin
                pend_avg[i]   = 0;
                pend_bound[i] = 0;
            end
            expected_px.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LINE_WIDTH:        width_reg = cfg_wdata;
                    REG_TEMPORAL_MODE:     mode_reg  = cfg_wdata[1:0];
                    REG_DIRECTIONAL_CHECK: dir_en    = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_column(in_beat_t'(s_tdata));
            if (m_tvalid && m_tready) check_result();
        end
        fail_total      <= fail_count;
        results_awaited <= expected_px.size();
        results_checked <= checked_count;
    end

endmodule

[bench/tb_deinterlace_line_filter.sv]
// Testbench top for the deinterlace line filter: stimulus, flow control and verdict.
module tb_deinterlace_line_filter;
    import dlf_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int fail_total;
    int results_awaited;
    int results_checked;

    // idle percentages per side, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int settings_run   = 0;

    // scratch rows for one line; the walk is padded for diagonal offsets
    pix_t row_up[MAX_LINE_WIDTH];
    pix_t row_dn[MAX_LINE_WIDTH];
    pix_t walk[MAX_LINE_WIDTH + 8];

    // random-phase settings: width, temporal mode, directional search
    int phase_width[8] = '{5, 9, 4, 17, 6, 31, 3, 12};
    int phase_mode[8]  = '{1, 2, 3, 0, 3, 1, 2, 0};
    int phase_dir[8]   = '{1, 0, 1, 1, 0, 1, 1, 0};

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    deinterlace_line_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    dlf_line_checker u_line_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .fail_total      (fail_total),
        .results_awaited (results_awaited),
        .results_checked (results_checked)
    );

    // result side: random backpressure, one decision per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAIL deinterlace_line_filter");
        $finish;
    end

    function automatic pix_t jitter(input int v, input int spread);
        int r;
        r = v + int'($urandom_range(0, 2 * spread)) - spread;
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return pix_t'(r);
    endfunction

    function automatic pix_t rail();
        return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endfunction

    function automatic in_beat_t flat_beat(input pix_t v);
        in_beat_t b;
        b = {12{v}};
        return b;
    endfunction

    // all three registers back to back; write enable stays high throughout
    task automatic program_filter(input int width, input int mode, input int dir);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_wdata <= CFG_DATA_W'(width);
        @(posedge aclk);
        cfg_index <= REG_TEMPORAL_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_index <= REG_DIRECTIONAL_CHECK;
        cfg_wdata <= CFG_DATA_W'(dir);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    // one input beat; random gap first, valid held until taken
    task automatic push_column(input in_beat_t b);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    // drain: every predicted result seen, then idle time for the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_awaited != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Styles: 0 pure noise, 1 diagonal edge (drives the directional search),
    // 2 near-flat field, 3 pixels only at the rails.
    task automatic send_line(input int w, input int style);
        int k, v, spread, avg;
        in_beat_t b;
        k = int'($urandom_range(0, 4)) - 2;
        v = $urandom_range(0, 255);
        for (int x = 0; x < w + 8; x++) begin
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 255);
            else
                v = jitter(v, 30);
            walk[x] = pix_t'(v);
        end
        for (int x = 0; x < w; x++) begin
            case (style)
                0: begin
                    row_up[x] = pix_t'($urandom);
                    row_dn[x] = pix_t'($urandom);
                end
                1: begin
                    row_up[x] = walk[x + 4 + k];
                    row_dn[x] = jitter(walk[x + 4 - k], 3);
                end
                2: begin
                    row_up[x] = jitter(walk[0], 6);
                    row_dn[x] = jitter(walk[0], 6);
                end
                default: begin
                    row_up[x] = rail();
                    row_dn[x] = rail();
                end
            endcase
        end
        case ($urandom_range(0, 2))
            0:       spread = 8;
            1:       spread = 40;
            default: spread = 255;
        endcase
        if (style == 2) spread = 4;
        for (int x = 0; x < w; x++) begin
            if (style == 0) begin
                b = in_beat_t'({$urandom, $urandom, $urandom});
            end else if (style == 3) begin
                b = in_beat_t'({$urandom, $urandom, $urandom});
                b.prev_above   = rail();  b.prev_below  = rail();
                b.next_above   = rail();  b.next_below  = rail();
                b.early_center = rail();  b.late_center = rail();
                b.early_up2    = rail();  b.early_down2 = rail();
                b.late_up2     = rail();  b.late_down2  = rail();
            end else begin
                avg = (int'(row_up[x]) + int'(row_dn[x])) >> 1;
                b.prev_above   = jitter(row_up[x], spread);
                b.prev_below   = jitter(row_dn[x], spread);
                b.next_above   = jitter(row_up[x], spread);
                b.next_below   = jitter(row_dn[x], spread);
                b.early_center = jitter(avg, spread);
                b.late_center  = jitter(b.early_center, spread);
                b.early_up2    = jitter(row_up[x], spread);
                b.early_down2  = jitter(row_dn[x], spread);
                b.late_up2     = jitter(row_up[x], spread);
                b.late_down2   = jitter(row_dn[x], spread);
            end
            b.cur_above = row_up[x];
            b.cur_below = row_dn[x];
            push_column(b);
        end
    endtask

    initial begin
        int phase_items, sel, style;
        in_beat_t b;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed lines ----
        // width 0 saturates up to the 4-pixel minimum
        program_filter(0, 0, 1);
        repeat (4) push_column(flat_beat(8'h00));
        repeat (4) push_column(flat_beat(8'hFF));
        // rails opposed on every field, flipping per column: huge bounds, wrap of d+bound
        for (int x = 0; x < 4; x++) begin
            b.cur_above    = (x % 2 != 0) ? 8'h00 : 8'hFF;
            b.cur_below    = ~b.cur_above;
            b.prev_above   = ~b.cur_above;
            b.prev_below   = b.cur_above;
            b.next_above   = b.cur_above;
            b.next_below   = ~b.cur_above;
            b.early_center = b.cur_above;
            b.late_center  = ~b.cur_above;
            b.early_up2    = ~b.cur_above;
            b.early_down2  = b.cur_above;
            b.late_up2     = b.cur_above;
            b.late_down2   = ~b.cur_above;
            push_column(b);
        end
        settle();
        // width shrinks mid-line: counter already past the new last column
        program_filter(8, 2, 1);
        for (int x = 0; x < 6; x++) begin
            b = flat_beat(8'h80);
            b.cur_above = pix_t'(x * 50);
            b.cur_below = pix_t'(255 - x * 50);
            push_column(b);
        end
        settle();
        program_filter(4, 2, 1);
        push_column(flat_beat(8'h40));
        settle();

        // ---- random phases: idle pattern cycles none / sender / receiver / both ----
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
                default: begin send_idle_pct <= 28; recv_stall_pct <= 28; end
            endcase
            program_filter(phase_width[ph], phase_mode[ph], phase_dir[ph]);
            phase_items = 0;
            while (phase_items < 26) begin
                sel = $urandom_range(0, 9);
                if (sel < 2)      style = 0;
                else if (sel < 6) style = 1;
                else if (sel < 8) style = 2;
                else              style = 3;
                send_line((phase_width[ph] < 4) ? 4 : phase_width[ph], style);
                phase_items += (phase_width[ph] < 4) ? 4 : phase_width[ph];
            end
            settle();
        end

        // ---- all-ones width saturates to the maximum; line then cut short ----
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        program_filter(8191, 3, 1);
        repeat (4) push_column(in_beat_t'({$urandom, $urandom, $urandom}));
        settle();
        program_filter(4, 3, 1);
        push_column(in_beat_t'({$urandom, $urandom, $urandom}));
        settle();

        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 beats_sent, results_checked, settings_run);
        $display("widths 4 to 31 plus an oversized width cut short, all temporal modes, "
                 , "directional search on and off");
        if (fail_total == 0 && results_awaited == 0) begin
            $display("PASS deinterlace_line_filter");
        end else begin
            $display("FAIL deinterlace_line_filter");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/dlf_pkg.sv
hdl/dlf_bound.sv
hdl/dlf_predict.sv
hdl/deinterlace_line_filter.sv
hdl/dlf_checker.sv
bench/dlf_line_checker.sv
bench/tb_deinterlace_line_filter.sv
